>>> src/epme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epme_pkg: shared types and constants of the entropy pool extractor
// Pool geometry, command codes, the MD5 round tables and their helpers.
// ----------------------------------------------------------------------------
package epme_pkg;

   localparam int POOL_WORDS_DEF = 128;

   localparam logic CMD_MIX     = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam int TAP0 = 99;
   localparam int TAP1 = 59;
   localparam int TAP2 = 31;
   localparam int TAP3 = 9;
   localparam int TAP4 = 7;

   typedef logic [31:0] word_type;

   function automatic word_type md5_k(input logic [5:0] step);
      word_type k;
      begin
         case (step)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   function automatic logic [4:0] md5_s(input logic [5:0] step);
      logic [4:0] s;
      begin
         case ({step[5:4], step[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
         endcase
         return s;
      end
   endfunction

   // Message word index for a step.
   function automatic logic [3:0] md5_g(input logic [5:0] step);
      logic [3:0] j;
      logic [3:0] g;
      begin
         j = step[3:0];
         case (step[5:4])
            2'd0: g = j;
            2'd1: g = 4'((j << 2) + j + 4'd1);
            2'd2: g = 4'((j << 1) + j + 4'd5);
            default: g = 4'((j << 3) - j);
         endcase
         return g;
      end
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] r);
      word_type y;
      begin
         y = (r == 5'd0) ? x : ((x << r) | (x >> (6'd32 - {1'b0, r})));
         return y;
      end
   endfunction

endpackage

>>> src/entropy_pool_md5_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entropy_pool_md5_extractor: entropy pool with MD5 extraction
// Sequencer around one pool RAM that mixes words in and extracts hashes.
// ----------------------------------------------------------------------------
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_cmd, req_entropy_word
//   rsp     | out       | rsp_valid, rsp_ready, rsp_hash_word0..3
//
// After reset a clearing pass writes zero to all POOL_WORDS entries, one a
// cycle, and req_ready stays low meanwhile.
// A mix word does six pool reads, each arriving in the cycle after its
// address on the single RAM port, and one write.
// An extract runs a compression per 16-word block, four mix-back words and
// a final compression: each MD5 step needs one read of the pool, so the RAM
// port sets the pace, and each compression ends with a hash update step.
// The result sits in an output register; while rsp_ready stalls it, req_ready
// stays low and holds the next item back, since one item is worked at a time.
// ----------------------------------------------------------------------------
module entropy_pool_md5_extractor #(
   parameter int POOL_WORDS = epme_pkg::POOL_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_entropy_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_word0,
   output logic [31:0] rsp_hash_word1,
   output logic [31:0] rsp_hash_word2,
   output logic [31:0] rsp_hash_word3
);

   localparam int AW = $clog2(POOL_WORDS);
   localparam int NBLK = POOL_WORDS / 16;
   localparam int BW = (NBLK > 1) ? $clog2(NBLK) : 1;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_MRD    = 4'd2;  // issue tap read
   localparam logic [3:0] S_MACC   = 4'd3;  // accumulate tap data
   localparam logic [3:0] S_MWR    = 4'd4;
   localparam logic [3:0] S_HRD    = 4'd5;  // issue message word read
   localparam logic [3:0] S_HSTEP  = 4'd6;  // run one MD5 step
   localparam logic [3:0] S_HADD   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   // Phases of an extract.
   localparam logic [1:0] PH_CHAIN = 2'd0;
   localparam logic [1:0] PH_MIX   = 2'd1;
   localparam logic [1:0] PH_FINAL = 2'd2;
   localparam logic [1:0] PH_NONE  = 2'd3;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [4:0]    rot_ff, rot_in;
   logic [31:0]   acc_ff, acc_in;
   logic [2:0]    tap_ff, tap_in;
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    mixn_ff, mixn_in;
   logic [BW-1:0] blk_ff, blk_in;
   logic [5:0]    step_ff, step_in;
   logic [31:0]   a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0]   h0_ff, h1_ff, h2_ff, h3_ff, h0_in, h1_in, h2_in, h3_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wdata, ram_rdata;
   logic [31:0]   b_next;
   logic [AW-1:0] tap_off;
   logic [AW-1:0] mix_idx;
   logic [31:0]   mix_word;

   epme_ram #(.WIDTH(32), .DEPTH(POOL_WORDS)) u_pool (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   epme_md5_round u_round (
      .step(step_ff), .a(a_ff), .b(b_ff), .c(c_ff), .d(d_ff),
      .m(ram_rdata), .b_next(b_next)
   );

   assign mix_idx = ptr_ff;

   always_comb begin
      case (tap_ff)
         3'd0: tap_off = AW'(epme_pkg::TAP0);
         3'd1: tap_off = AW'(epme_pkg::TAP1);
         3'd2: tap_off = AW'(epme_pkg::TAP2);
         3'd3: tap_off = AW'(epme_pkg::TAP3);
         3'd4: tap_off = AW'(epme_pkg::TAP4);
         default: tap_off = '0;
      endcase
      case (mixn_ff)
         2'd0: mix_word = h0_ff;
         2'd1: mix_word = h1_ff;
         2'd2: mix_word = h2_ff;
         default: mix_word = h3_ff;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; ptr_in = ptr_ff; rot_in = rot_ff;
      acc_in = acc_ff; tap_in = tap_ff; phase_in = phase_ff; mixn_in = mixn_ff;
      blk_in = blk_ff; step_in = step_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      h0_in = h0_ff; h1_in = h1_ff; h2_in = h2_ff; h3_in = h3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we = 1'b0; ram_addr = '0; ram_wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1; ram_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(POOL_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_cmd == epme_pkg::CMD_MIX) begin
                  // The pointer and rotation move when the word is taken.
                  acc_in = epme_pkg::rotl(req_entropy_word, rot_ff);
                  ptr_in = ptr_ff - 1'b1;
                  rot_in = rot_ff + ((ptr_ff == AW'(1)) ? 5'd14 : 5'd7);
                  tap_in = '0; phase_in = PH_NONE;
                  state_in = S_MRD;
               end else begin
                  h0_in = epme_pkg::IV_A; h1_in = epme_pkg::IV_B;
                  h2_in = epme_pkg::IV_C; h3_in = epme_pkg::IV_D;
                  a_in = epme_pkg::IV_A; b_in = epme_pkg::IV_B;
                  c_in = epme_pkg::IV_C; d_in = epme_pkg::IV_D;
                  blk_in = '0; step_in = '0; phase_in = PH_CHAIN;
                  state_in = S_HRD;
               end
            end
         end
         S_MRD: begin
            ram_addr = mix_idx + tap_off;
            state_in = S_MACC;
         end
         S_MACC: begin
            acc_in = acc_ff ^ ram_rdata;
            if (tap_ff == 3'd5) begin
               state_in = S_MWR;
            end else begin
               tap_in = tap_ff + 3'd1;
               state_in = S_MRD;
            end
         end
         S_MWR: begin
            ram_we = 1'b1; ram_addr = mix_idx;
            ram_wdata = epme_pkg::rotl(acc_ff, 5'd1);
            if (phase_ff == PH_MIX) begin
               if (mixn_ff == 2'd3) begin
                  phase_in = PH_FINAL; blk_in = '0; step_in = '0;
                  a_in = h0_ff; b_in = h1_ff; c_in = h2_ff; d_in = h3_ff;
                  state_in = S_HRD;
               end else begin
                  mixn_in = mixn_ff + 2'd1;
                  state_in = S_HADD;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_HRD: begin
            ram_addr = AW'({blk_ff, epme_pkg::md5_g(step_ff)});
            state_in = S_HSTEP;
         end
         S_HSTEP: begin
            a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_next;
            step_in = step_ff + 6'd1;
            state_in = (step_ff == 6'd63) ? S_HADD : S_HRD;
         end
         S_HADD: begin
            // Either finish a compression, or start the next mix-back word.
            if (phase_ff == PH_MIX) begin
               acc_in = epme_pkg::rotl(mix_word, rot_ff);
               ptr_in = ptr_ff - 1'b1;
               rot_in = rot_ff + ((ptr_ff == AW'(1)) ? 5'd14 : 5'd7);
               tap_in = '0;
               state_in = S_MRD;
            end else begin
               h0_in = h0_ff + a_ff; h1_in = h1_ff + b_ff;
               h2_in = h2_ff + c_ff; h3_in = h3_ff + d_ff;
               a_in = h0_ff + a_ff; b_in = h1_ff + b_ff;
               c_in = h2_ff + c_ff; d_in = h3_ff + d_ff;
               step_in = '0;
               if (phase_ff == PH_FINAL) begin
                  state_in = S_OUT;
               end else if (blk_ff == BW'(NBLK - 1)) begin
                  phase_in = PH_MIX; mixn_in = '0;
                  state_in = S_HADD;
               end else begin
                  blk_in = blk_ff + 1'b1;
                  state_in = S_HRD;
               end
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The tap counter runs 0..4 for the taps and 5 for the word itself.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; ptr_ff <= '0; rot_ff <= '0;
         rsp_valid_ff <= 1'b0; phase_ff <= PH_NONE; tap_ff <= '0;
         mixn_ff <= '0; blk_ff <= '0; step_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; ptr_ff <= ptr_in; rot_ff <= rot_in;
         rsp_valid_ff <= rsp_valid_in; phase_ff <= phase_in; tap_ff <= tap_in;
         mixn_ff <= mixn_in; blk_ff <= blk_in; step_ff <= step_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      h0_ff <= h0_in; h1_ff <= h1_in; h2_ff <= h2_in; h3_ff <= h3_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash_word0 = h0_ff;
   assign rsp_hash_word1 = h1_ff;
   assign rsp_hash_word2 = h2_ff;
   assign rsp_hash_word3 = h3_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req_ready;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

   property p_rsp_from_out;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT;
   endproperty
   a_rsp_from_out: assert property (p_rsp_from_out) else $error("response outside OUT");

   property p_hash_stable;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && !rsp_ready) |=> $stable(h0_ff) && $stable(h3_ff);
   endproperty
   a_hash_stable: assert property (p_hash_stable) else $error("hash changed while held");

   property p_tap_range;
      @(posedge clock) disable iff (reset) (state_ff == S_MWR) |-> tap_ff == 3'd5;
   endproperty
   a_tap_range: assert property (p_tap_range) else $error("write before all taps read");

endmodule

>>> src/epme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epme_ram: generic single-port RAM
// One address per cycle, a write also reading out the old word; registered read data.
// ----------------------------------------------------------------------------
module epme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

>>> src/epme_md5_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epme_md5_round: one MD5 step
// Combinational new b word for one step of 64; the caller rotates the others.
// ----------------------------------------------------------------------------
module epme_md5_round (
   input  logic [5:0]  step,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] c,
   input  logic [31:0] d,
   input  logic [31:0] m,
   output logic [31:0] b_next
);

   logic [31:0] f;
   logic [31:0] t;

   always_comb begin
      case (step[5:4])
         2'd0: f = d ^ (b & (c ^ d));
         2'd1: f = c ^ (d & (b ^ c));
         2'd2: f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      t = a + f + epme_pkg::md5_k(step) + m;
      b_next = b + epme_pkg::rotl(t, epme_pkg::md5_s(step));
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the entropy pool extractor
// Random and directed mix and extract words go in. An internal pool model
// predicts each extracted hash, and every returned word is compared with it.
// ----------------------------------------------------------------------------
module tb;

   localparam int NPOOL     = 128;
   localparam int WD_LIMIT  = 20000;
   localparam int N_RANDOM  = 400;
   localparam int HOLD_LONG = 3000;

   typedef struct packed {
      logic        cmd;
      logic [31:0] data;
   } req_word_type;

   typedef struct packed {
      logic [31:0] h0;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
   } hash_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [31:0] req_entropy_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_hash_word0, rsp_hash_word1, rsp_hash_word2, rsp_hash_word3;

   entropy_pool_md5_extractor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_entropy_word(req_entropy_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hash_word0(rsp_hash_word0), .rsp_hash_word1(rsp_hash_word1),
      .rsp_hash_word2(rsp_hash_word2), .rsp_hash_word3(rsp_hash_word3)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The predictor's own copy of the block state.
   logic [31:0] pool_m [NPOOL];
   logic [6:0]  ptr_m;
   logic [4:0]  rot_m;

   req_word_type pending_words[$];
   hash_type     expected_hashes[$];
   int        mismatches = 0;
   int        idle_cycles = 0;
   bit        calm = 0;        // no idling in the last part of the run
   bit        hold_rsp = 0;    // long receiver hold-off requested
   int        hold_left = 0;
   bit        drain_pause = 0;
   bit        req_accepted = 0;

   function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
      r = r & 31;
      return (r == 0) ? x : ((x << r) | (x >> (32 - r)));
   endfunction

   function automatic void stir_word(input logic [31:0] word);
      logic [31:0] w;
      logic [6:0]  i;
      w = rol32(word, rot_m);
      i = ptr_m - 7'd1;
      ptr_m = i;
      rot_m = rot_m + ((i != 0) ? 5'd7 : 5'd14);
      w ^= pool_m[7'(i + 99)] ^ pool_m[7'(i + 59)] ^ pool_m[7'(i + 31)];
      w ^= pool_m[7'(i + 9)] ^ pool_m[7'(i + 7)] ^ pool_m[i];
      pool_m[i] = rol32(w, 1);
   endfunction

   function automatic void compress_block(ref logic [31:0] h[4], input int base);
      logic [31:0] a, b, c, d, f, t, k;
      int j, g, s, rnd;
      int shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      logic [31:0] sine[64] = '{
         32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
         32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
         32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
         32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
         32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
         32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
         32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
         32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
         32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
         32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
         32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
      a = h[0]; b = h[1]; c = h[2]; d = h[3];
      for (int st = 0; st < 64; st++) begin
         rnd = st >> 4;
         j = st & 15;
         case (rnd)
            0: begin f = d ^ (b & (c ^ d)); g = j; end
            1: begin f = c ^ (d & (b ^ c)); g = (5 * j + 1) & 15; end
            2: begin f = b ^ c ^ d; g = (3 * j + 5) & 15; end
            default: begin f = c ^ (b | ~d); g = (7 * j) & 15; end
         endcase
         k = sine[st];
         s = shifts[(rnd << 2) | (j & 3)];
         t = a + f + k + pool_m[(base + g) & (NPOOL - 1)];
         t = b + rol32(t, s);
         a = d; d = c; c = b; b = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
   endfunction

   // Applies one accepted word to the model; an extract queues its hash.
   function automatic void predict_word(input req_word_type rw);
      logic [31:0] h[4];
      if (rw.cmd == epme_pkg::CMD_MIX) begin
         stir_word(rw.data);
         return;
      end
      h = '{epme_pkg::IV_A, epme_pkg::IV_B, epme_pkg::IV_C, epme_pkg::IV_D};
      for (int blk = 0; blk < NPOOL; blk += 16) compress_block(h, blk);
      for (int n = 0; n < 4; n++) stir_word(h[n]);
      compress_block(h, 0);
      expected_hashes.push_back('{h[0], h[1], h[2], h[3]});
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %08h expected %08h", what, got, want);
      mismatches++;
   endtask

   // Driver: inputs change on the falling edge, idling comes in bursts.
   int gap_left = 0;
   always @(negedge clock) begin
      req_word_type rw;
      if (!reset) begin
         if (!req_valid || req_accepted) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               gap_left <= $urandom_range(1, 16);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !drain_pause) begin
               rw = pending_words.pop_front();
               req_cmd <= rw.cmd;
               req_entropy_word <= rw.data;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, also in bursts, plus a long hold-off counted here.
   int stall_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_rsp) begin
            hold_left <= HOLD_LONG;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: samples both channels at the rising edge.
   always @(posedge clock) begin
      bit       seen;
      hash_type e;
      seen = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_word('{req_cmd, req_entropy_word});
            seen = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            seen = 1'b1;
            if (expected_hashes.size() == 0) begin
               report_mismatch("unexpected hash", rsp_hash_word0, 32'h0);
            end else begin
               e = expected_hashes.pop_front();
               if (rsp_hash_word0 !== e.h0) report_mismatch("hash_word0", rsp_hash_word0, e.h0);
               if (rsp_hash_word1 !== e.h1) report_mismatch("hash_word1", rsp_hash_word1, e.h1);
               if (rsp_hash_word2 !== e.h2) report_mismatch("hash_word2", rsp_hash_word2, e.h2);
               if (rsp_hash_word3 !== e.h3) report_mismatch("hash_word3", rsp_hash_word3, e.h3);
            end
         end
         idle_cycles <= seen ? 0 : idle_cycles + 1;
      end
      req_accepted <= !reset && req_valid && req_ready;
   end

   // Watchdog on cycles without a handshake on either channel; the clearing pass and a
   // full extract behind a long hold-off both fit well inside the limit.
   always @(posedge clock) begin
      if (!reset && idle_cycles >= WD_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic add_word(input logic cmd, input logic [31:0] data);
      pending_words.push_back('{cmd, data});
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_hashes.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int kind;
      for (int n = 0; n < NPOOL; n++) pool_m[n] = '0;
      ptr_m = '0;
      rot_m = '0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: extract from the cleared pool, field extremes, the
      // zero-rotation first mix, a pointer wrap, and an extract that
      // ignores its data word.
      add_word(epme_pkg::CMD_EXTRACT, 32'h0);
      add_word(epme_pkg::CMD_MIX, 32'h0);
      add_word(epme_pkg::CMD_MIX, 32'hffff_ffff);
      add_word(epme_pkg::CMD_MIX, 32'h8000_0001);
      add_word(epme_pkg::CMD_MIX, 32'h5555_aaaa);
      add_word(epme_pkg::CMD_EXTRACT, 32'hffff_ffff);
      for (int n = 0; n < 12; n++) add_word(epme_pkg::CMD_MIX, $urandom());
      add_word(epme_pkg::CMD_EXTRACT, 32'hdead_beef);

      // Wait until every hash has come back, then pause the sender.
      wait_drained();
      drain_pause = 1;
      repeat (20) @(posedge clock);
      drain_pause = 0;

      // Long receiver hold-off while extracts keep coming, so the block
      // fills and holds its input back.
      hold_rsp = 1;
      for (int n = 0; n < 3; n++) add_word(epme_pkg::CMD_EXTRACT, $urandom());
      wait (hold_left != 0);
      hold_rsp = 0;
      wait (hold_left == 0);
      wait_drained();

      // Random part: mostly mixes, enough extracts for dozens of hashes,
      // and enough mixes in total to wrap the pointer.
      for (int n = 0; n < N_RANDOM; n++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) add_word(epme_pkg::CMD_EXTRACT, $urandom());
         else add_word(epme_pkg::CMD_MIX, $urandom());
         if (n == N_RANDOM - 60) begin
            wait_drained();
            calm = 1;
         end
      end
      wait_drained();
      repeat (1500) @(posedge clock);
      if (mismatches == 0 && expected_hashes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
src/epme_pkg.sv
src/epme_ram.sv
src/epme_md5_round.sv
src/entropy_pool_md5_extractor.sv
sim/tb.sv
